### rtl/rrf_pkg.sv
package rrf_pkg;

	localparam int SLOT_IN_W        = 3;
	localparam int SEQ_W            = 4;
	localparam int LEN_WIRELESS     = 78;
	localparam int LEN_FIRST_WIRED  = 32;
	localparam int LEN_SECOND_WIRED = 48;
	localparam int CRC_LEN          = 4;
	localparam int PAIR_W           = $clog2(LEN_WIRELESS / 2);
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [PAIR_W-1:0] PAIRS_WIRELESS     = PAIR_W'(LEN_WIRELESS / 2);
	localparam logic [PAIR_W-1:0] PAIRS_FIRST_WIRED  = PAIR_W'(LEN_FIRST_WIRED / 2);
	localparam logic [PAIR_W-1:0] PAIRS_SECOND_WIRED = PAIR_W'(LEN_SECOND_WIRED / 2);
	localparam logic [PAIR_W-1:0] CRC_PAIR           = PAIR_W'((LEN_WIRELESS - CRC_LEN) / 2);

	localparam logic [7:0] HDR_G1_WIRED = 8'h05;
	localparam logic [7:0] HDR_G1_WL    = 8'h11;
	localparam logic [7:0] FLAG_G1_WL   = 8'hC0;
	localparam logic [7:0] CMD_G1       = 8'h01;
	localparam logic [7:0] HDR_G2_WIRED = 8'h02;
	localparam logic [7:0] HDR_G2_WL    = 8'h31;
	localparam logic [7:0] TAG_G2_WL    = 8'h10;
	localparam logic [7:0] CMD_G2       = 8'h03;
	localparam logic [SEQ_W-1:0] SEQ_MASK = 4'hF;

	localparam logic [7:0]  CRC_SEED_BYTE = 8'hA2;
	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

	typedef struct packed {
		logic             gen2;
		logic             wl;
		logic [SEQ_W-1:0] seq;
		logic [7:0]       large_motor;
		logic [7:0]       small_motor;
	} req_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	// reflected crc-32, one byte lsb first
	function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	localparam logic [31:0] CRC_INIT = crc_byte(32'hFFFF_FFFF, CRC_SEED_BYTE);

endpackage

### rtl/rrf_front.sv
module rrf_front import rrf_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [SLOT_IN_W-1:0] pad_slot,
	input  logic                 second_generation,
	input  logic                 wireless,
	input  logic [7:0]           large_motor,
	input  logic [7:0]           small_motor,
	output logic                 q_push,
	output req_t                 q_req,
	input  logic                 q_full
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int MW = 9;

	function automatic logic [SW-1:0] slot_index(logic [SLOT_IN_W-1:0] s);
		logic [MW-1:0] v;
		v = MW'(s);
		for (int i = 0; i < 8; i++) begin
			if (v >= MW'(SLOT_COUNT)) begin
				v = v - MW'(SLOT_COUNT);
			end
		end
		return v[SW-1:0];
	endfunction

	logic [SEQ_W-1:0]      seq_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] seq_valid_q;
	logic [SEQ_W-1:0]      rd_seq_s1;
	logic                  rd_valid_s1;
	logic                  valid_s1;
	logic [SW-1:0]         slot_s1;
	logic                  gen2_s1;
	logic                  wl_s1;
	logic [7:0]            large_s1;
	logic [7:0]            small_s1;
	logic                  accept;
	logic [SW-1:0]         in_slot;
	logic [SEQ_W-1:0]      cur_seq;
	logic                  seq_write;

	// one request in flight so a slot read never races its own write-back
	assign full      = valid_s1 | q_full;
	assign accept    = push & ~full;
	assign in_slot   = slot_index(pad_slot);
	assign cur_seq   = rd_valid_s1 ? rd_seq_s1 : '0;
	assign q_push    = valid_s1 & ~q_full;
	assign seq_write = q_push & gen2_s1 & wl_s1;

	always_comb begin
		q_req.gen2        = gen2_s1;
		q_req.wl          = wl_s1;
		q_req.seq         = (gen2_s1 & wl_s1) ? cur_seq : '0;
		q_req.large_motor = large_s1;
		q_req.small_motor = small_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			seq_valid_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
			if (seq_write) begin
				seq_valid_q[slot_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_seq_s1   <= seq_mem[in_slot];
			rd_valid_s1 <= seq_valid_q[in_slot];
			slot_s1     <= in_slot;
			gen2_s1     <= second_generation;
			wl_s1       <= wireless;
			large_s1    <= large_motor;
			small_s1    <= small_motor;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_write) begin
			seq_mem[slot_s1] <= (cur_seq + SEQ_W'(1)) & SEQ_MASK;
		end
	end

	fe_hold_a: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && q_full) |=> (valid_s1 && $stable(slot_s1)))
		else $error("front dropped a pending word");

	fe_block_a: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (full && valid_s1))
		else $error("front accepted while a word was pending");

endmodule

### rtl/rrf_fifo.sv
module rrf_fifo import rrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  req_t wr_data,
	output logic q_full,
	input  logic rd_en,
	output req_t rd_data,
	output logic q_empty
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	req_t          slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (count_q == CW'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en & ~q_full;
	assign do_rd   = rd_en & ~q_empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/rrf_back.sv
module rrf_back import rrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        q_req,
	input  logic        q_empty,
	output logic        q_pop,
	output logic [15:0] byte_pair,
	output logic        last_pair,
	output logic        empty,
	input  logic        pop
);

	function automatic logic [7:0] report_byte(req_t r, logic [6:0] idx);
		logic [7:0] b;
		b = '0;
		if (!r.gen2 && !r.wl) begin
			case (idx)
				7'd0:    b = HDR_G1_WIRED;
				7'd1:    b = CMD_G1;
				7'd4:    b = r.small_motor;
				7'd5:    b = r.large_motor;
				default: b = '0;
			endcase
		end else if (!r.gen2) begin
			case (idx)
				7'd0:    b = HDR_G1_WL;
				7'd1:    b = FLAG_G1_WL;
				7'd3:    b = CMD_G1;
				7'd6:    b = r.small_motor;
				7'd7:    b = r.large_motor;
				default: b = '0;
			endcase
		end else if (!r.wl) begin
			case (idx)
				7'd0:    b = HDR_G2_WIRED;
				7'd1:    b = CMD_G2;
				7'd3:    b = r.small_motor;
				7'd4:    b = r.large_motor;
				default: b = '0;
			endcase
		end else begin
			case (idx)
				7'd0:    b = HDR_G2_WL;
				7'd1:    b = {r.seq, 4'd0};
				7'd2:    b = TAG_G2_WL;
				7'd3:    b = CMD_G2;
				7'd5:    b = r.small_motor;
				7'd6:    b = r.large_motor;
				default: b = '0;
			endcase
		end
		return b;
	endfunction

	back_state_t       state_q;
	back_state_t       state_d;
	req_t              req_q;
	logic [PAIR_W-1:0] k_q;
	logic [31:0]       crc_q;
	logic [15:0]       out_data_q;
	logic              out_last_q;
	logic              out_v_q;
	logic              adv;
	logic              emit;
	logic [7:0]        lo_byte;
	logic [7:0]        hi_byte;
	logic [15:0]       pair_w;
	logic [PAIR_W-1:0] pairs_total;
	logic              last_w;
	logic              crc_feed;

	assign adv       = ~out_v_q | pop;
	assign empty     = ~out_v_q;
	assign byte_pair = out_data_q;
	assign last_pair = out_last_q;

	always_comb begin
		lo_byte     = report_byte(req_q, {k_q, 1'b0});
		hi_byte     = report_byte(req_q, {k_q, 1'b1});
		pairs_total = req_q.wl ? PAIRS_WIRELESS
		            : (req_q.gen2 ? PAIRS_SECOND_WIRED : PAIRS_FIRST_WIRED);
		last_w      = (k_q == pairs_total - PAIR_W'(1));
		// crc trailer is little endian after the covered bytes
		if (req_q.wl && k_q == CRC_PAIR) begin
			pair_w = ~crc_q[15:0];
		end else if (req_q.wl && k_q == CRC_PAIR + PAIR_W'(1)) begin
			pair_w = ~crc_q[31:16];
		end else begin
			pair_w = {hi_byte, lo_byte};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (adv && last_w) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		emit     = 1'b0;
		case (state_q)
			BK_IDLE: q_pop = ~q_empty;
			BK_RUN:  emit  = adv;
			default: begin
				q_pop = 1'b0;
				emit  = 1'b0;
			end
		endcase
		crc_feed = emit & req_q.wl & (k_q < CRC_PAIR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_v_q <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (q_pop) begin
				k_q <= '0;
			end else if (emit) begin
				k_q <= k_q + PAIR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_req;
			crc_q <= CRC_INIT;
		end else if (crc_feed) begin
			crc_q <= crc_byte(crc_byte(crc_q, lo_byte), hi_byte);
		end
		if (emit) begin
			out_data_q <= pair_w;
			out_last_q <= last_w;
		end
	end

	bk_bound_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN) |-> (k_q < PAIRS_WIRELESS))
		else $error("pair index ran past the longest report");

	bk_wired_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN && !req_q.wl) |-> (k_q < PAIRS_SECOND_WIRED))
		else $error("wired report ran past its length");

	bk_load_a: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == BK_RUN && k_q == '0 && crc_q == CRC_INIT))
		else $error("report did not start from a clean crc and index");

	bk_last_a: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_w) |=> (state_q == BK_IDLE && out_v_q && out_last_q))
		else $error("final word not marked or sequencer did not stop");

endmodule

### rtl/rumble_report_framer_core.sv
// Rumble report framer: each request (slot, pad generation, transport, two motor levels) becomes
// one output report sent as 16, 24 or 39 words of two bytes, earlier byte low, last_pair set on
// the final word. The front stage registers a request and reads the slot's sequence counter,
// advancing it when a second-gen wireless request enters the queue; it takes no new request
// while one is held. A two-entry queue then lets it take more requests while reports are still
// going out. The back sequencer loads a request from the queue and then emits one word per
// cycle while pop is held; that pair sequencer sets the rate. The crc is folded in two bytes
// per cycle alongside the emitted words and is ready when the trailer is reached. Sequence
// counters live in a small memory with one valid bit per slot, so no clearing pass follows reset.
module rumble_report_framer_core import rrf_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [SLOT_IN_W-1:0] pad_slot,
	input  logic                 second_generation,
	input  logic                 wireless,
	input  logic [7:0]           large_motor,
	input  logic [7:0]           small_motor,
	output logic                 empty,
	input  logic                 pop,
	output logic [15:0]          byte_pair,
	output logic                 last_pair
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	req_t q_wr;
	req_t q_rd;

	rrf_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.pad_slot         (pad_slot),
		.second_generation(second_generation),
		.wireless         (wireless),
		.large_motor      (large_motor),
		.small_motor      (small_motor),
		.q_push           (q_push),
		.q_req            (q_wr),
		.q_full           (q_full)
	);

	rrf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wr),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rd),
		.q_empty(q_empty)
	);

	rrf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_req    (q_rd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.byte_pair(byte_pair),
		.last_pair(last_pair),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

### sim/rumble_report_checker.sv
module rumble_report_checker import rrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [SLOT_IN_W-1:0] pad_slot,
	input  logic                 second_generation,
	input  logic                 wireless,
	input  logic [7:0]           large_motor,
	input  logic [7:0]           small_motor,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [15:0]          byte_pair,
	input  logic                 last_pair,
	output int                   fail_count,
	output int                   words_waiting,
	output int                   words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0]  ID_G1_WIRED = 8'h05;
	localparam logic [7:0]  ID_G1_RADIO = 8'h11;
	localparam logic [7:0]  G1_RADIO_FLAGS = 8'hC0;
	localparam logic [7:0]  G1_MOTOR_CMD = 8'h01;
	localparam logic [7:0]  ID_G2_WIRED = 8'h02;
	localparam logic [7:0]  ID_G2_RADIO = 8'h31;
	localparam logic [7:0]  G2_RADIO_TAG = 8'h10;
	localparam logic [7:0]  G2_MOTOR_CMD = 8'h03;
	localparam logic [7:0]  RADIO_CRC_PREFIX = 8'hA2;
	localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;
	localparam int          RADIO_LEN = 78;
	localparam int          G1_WIRED_LEN = 32;
	localparam int          G2_WIRED_LEN = 48;

	typedef struct packed {
		logic [15:0] pair;
		logic        last;
	} report_word_t;

	report_word_t expected_words[$];
	logic [3:0]   seq_count [8];

	// one data bit at a time, lsb first
	function automatic logic [31:0] crc32_update(logic [31:0] acc, logic [7:0] data);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = acc[0] ^ data[i];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ REFLECTED_POLY;
			end
		end
		return acc;
	endfunction

	task automatic frame_report(input logic [2:0] slot, input logic gen2, input logic radio,
			input logic [7:0] big, input logic [7:0] little);
		logic [7:0]  rep [RADIO_LEN];
		int          len;
		logic [31:0] crc;
		report_word_t w;
		foreach (rep[i]) rep[i] = 8'h00;
		// slot field is as wide as the counter store, so no folding is needed
		if (!gen2) begin
			if (radio) begin
				rep[0] = ID_G1_RADIO;
				rep[1] = G1_RADIO_FLAGS;
				rep[3] = G1_MOTOR_CMD;
				rep[6] = little;
				rep[7] = big;
				len = RADIO_LEN;
			end else begin
				rep[0] = ID_G1_WIRED;
				rep[1] = G1_MOTOR_CMD;
				rep[4] = little;
				rep[5] = big;
				len = G1_WIRED_LEN;
			end
		end else if (radio) begin
			rep[0] = ID_G2_RADIO;
			rep[1] = {seq_count[slot], 4'h0};
			rep[2] = G2_RADIO_TAG;
			rep[3] = G2_MOTOR_CMD;
			rep[5] = little;
			rep[6] = big;
			seq_count[slot] = seq_count[slot] + 4'd1;
			len = RADIO_LEN;
		end else begin
			rep[0] = ID_G2_WIRED;
			rep[1] = G2_MOTOR_CMD;
			rep[3] = little;
			rep[4] = big;
			len = G2_WIRED_LEN;
		end
		if (radio) begin
			crc = crc32_update(32'hFFFF_FFFF, RADIO_CRC_PREFIX);
			for (int i = 0; i < len - 4; i++) crc = crc32_update(crc, rep[i]);
			crc = ~crc;
			rep[len-4] = crc[7:0];
			rep[len-3] = crc[15:8];
			rep[len-2] = crc[23:16];
			rep[len-1] = crc[31:24];
		end
		for (int k = 0; k < len / 2; k++) begin
			w.pair = {rep[2*k+1], rep[2*k]};
			w.last = (2 * k + 2 == len);
			expected_words.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (seq_count[i]) seq_count[i] = 4'd0;
			expected_words.delete();
			fail_count = 0;
			words_checked = 0;
			words_waiting = 0;
		end else begin
			if (push && !full) begin
				frame_report(pad_slot, second_generation, wireless, large_motor, small_motor);
			end
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, got pair %h last %b", $time, byte_pair,
						last_pair);
					fail_count++;
				end else begin
					if (byte_pair !== expected_words[0].pair) begin
						$display("%0t: byte_pair mismatch, expected %h, got %h", $time,
							expected_words[0].pair, byte_pair);
						fail_count++;
					end
					if (last_pair !== expected_words[0].last) begin
						$display("%0t: last_pair mismatch, expected %b, got %b", $time,
							expected_words[0].last, last_pair);
						fail_count++;
					end
					void'(expected_words.pop_front());
					words_checked++;
				end
			end
			words_waiting = expected_words.size();
		end
	end

endmodule

### sim/testbench.sv
module testbench import rrf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [SLOT_IN_W-1:0] pad_slot = '0;
	logic                 second_generation = 1'b0;
	logic                 wireless = 1'b0;
	logic [7:0]           large_motor = 8'h00;
	logic [7:0]           small_motor = 8'h00;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [15:0]          byte_pair;
	logic                 last_pair;

	int fail_count;
	int words_waiting;
	int words_checked;
	int requests_sent = 0;
	int radio_g2_sent = 0;
	bit sender_calm = 1'b0;

	rumble_report_framer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pad_slot(pad_slot),
		.second_generation(second_generation),
		.wireless(wireless),
		.large_motor(large_motor),
		.small_motor(small_motor),
		.empty(empty),
		.pop(pop),
		.byte_pair(byte_pair),
		.last_pair(last_pair)
	);

	rumble_report_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pad_slot(pad_slot),
		.second_generation(second_generation),
		.wireless(wireless),
		.large_motor(large_motor),
		.small_motor(small_motor),
		.empty(empty),
		.pop(pop),
		.byte_pair(byte_pair),
		.last_pair(last_pair),
		.fail_count(fail_count),
		.words_waiting(words_waiting),
		.words_checked(words_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len(bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(input logic [2:0] slot, input logic gen2, input logic radio,
			input logic [7:0] big, input logic [7:0] little);
		int gap;
		@(negedge clk);
		push <= 1'b1;
		pad_slot <= slot;
		second_generation <= gen2;
		wireless <= radio;
		large_motor <= big;
		small_motor <= little;
		@(posedge clk);
		while (full) @(posedge clk);
		requests_sent++;
		if (gen2 && radio) begin
			radio_g2_sent++;
		end
		if ($urandom_range(0, 19) == 0) begin
			sender_calm = !sender_calm;
		end
		gap = idle_len(sender_calm);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			pad_slot <= SLOT_IN_W'($urandom);
			second_generation <= 1'($urandom);
			wireless <= 1'($urandom);
			large_motor <= 8'($urandom);
			small_motor <= 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_random_request();
		int          kind;
		logic [2:0]  slot;
		logic [7:0]  big;
		logic [7:0]  little;
		kind = $urandom_range(0, 99);
		// crowd half the traffic onto two slots so their counters wrap
		slot = $urandom_range(0, 1) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
		big = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
		little = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
		if (kind < 45) begin
			send_request(slot, 1'b1, 1'b1, big, little);
		end else if (kind < 65) begin
			send_request(slot, 1'b0, 1'b1, big, little);
		end else if (kind < 85) begin
			send_request(slot, 1'b1, 1'b0, big, little);
		end else begin
			send_request(slot, 1'b0, 1'b0, big, little);
		end
	endtask

	// receiver: random stalls, calm stretches, two long hold-offs to back up the input
	initial begin
		int  cyc;
		int  stall_left;
		int  hold_left;
		bit  calm;
		cyc = 0;
		stall_left = 0;
		hold_left = 0;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 1500 || cyc == 9000) begin
				hold_left = 400;
			end
			if (cyc % 250 == 0) begin
				calm = ($urandom_range(0, 2) == 0);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				stall_left = idle_len(calm);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// each layout at the motor extremes
		send_request(3'd0, 1'b0, 1'b0, 8'h00, 8'h00);
		send_request(3'd7, 1'b0, 1'b0, 8'hFF, 8'hFF);
		send_request(3'd2, 1'b0, 1'b1, 8'hFF, 8'h00);
		send_request(3'd4, 1'b0, 1'b1, 8'h00, 8'hFF);
		send_request(3'd1, 1'b1, 1'b0, 8'hFF, 8'h00);
		send_request(3'd7, 1'b1, 1'b0, 8'h00, 8'hFF);
		// first-gen wireless on the same slot must leave its counter alone
		send_request(3'd2, 1'b1, 1'b1, 8'h5A, 8'hA5);
		send_request(3'd2, 1'b0, 1'b1, 8'h5A, 8'hA5);
		send_request(3'd2, 1'b1, 1'b1, 8'hA5, 8'h5A);
		send_request(3'd7, 1'b1, 1'b1, 8'hFF, 8'hFF);
		send_request(3'd0, 1'b1, 1'b1, 8'h00, 8'h00);
		for (int i = 0; i < 4; i++) begin
			send_request(3'd3, 1'b1, 1'b1, 8'(8'h11 * i), 8'(8'hEE - 8'h11 * i));
		end

		for (int i = 0; i < 250; i++) begin
			send_random_request();
		end

		@(negedge clk);
		push <= 1'b0;
		while (words_waiting != 0) @(negedge clk);
		repeat (60) @(negedge clk);

		$display("%0d requests sent (%0d wireless second-gen), %0d words compared",
			requests_sent, radio_g2_sent, words_checked);
		$display("all four layouts, counter wrap on shared slots, input backed up twice");
		if (fail_count == 0 && words_waiting == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

### files.f
rtl/rrf_pkg.sv
rtl/rrf_front.sv
rtl/rrf_fifo.sv
rtl/rrf_back.sv
rtl/rumble_report_framer_core.sv
sim/rumble_report_checker.sv
sim/testbench.sv
